### rtl/uwa_pkg.sv
// shared constants, types and coefficient tables of the upwind advection block
package uwa_pkg;

    localparam int GRID_X  = 32;
    localparam int GRID_Y  = 32;
    localparam int X_W     = $clog2(GRID_X);
    localparam int Y_W     = $clog2(GRID_Y);
    localparam int CELL_W  = X_W + Y_W;
    localparam int CELLS   = 1 << CELL_W;
    localparam int IDX_W   = 5;
    localparam int XF_W    = (X_W > IDX_W ? X_W : IDX_W) + 1;
    localparam int YF_W    = (Y_W > IDX_W ? Y_W : IDX_W) + 1;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 40;
    localparam int A_W     = 64;
    localparam int B_W     = 33;
    localparam int CHUNK_W = 16;
    localparam int PP_W    = CHUNK_W + 1 + B_W;
    localparam int ACC_W   = 98;
    localparam int TOT_W   = ACC_W - 16;
    localparam int STEP_W  = 4;
    localparam int REG_W   = 3;

    localparam logic [STEP_W-1:0] STEP_CENTRE  = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_UV_LAST = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_X_LAST  = STEP_W'(6);
    localparam logic [STEP_W-1:0] STEP_LAST    = STEP_W'(12);
    localparam logic [1:0]        CHUNK_LAST   = 2'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_RATE  = 1'b1;

    localparam logic signed [VAL_W-1:0] RST_UPWIND  = 32'sd33860;
    localparam logic signed [VAL_W-1:0] RST_CENTRAL = 32'sd169301;

    typedef enum logic [REG_W-1:0] {
        REG_USX  = 3'd0,
        REG_USY  = 3'd1,
        REG_CSX  = 3'd2,
        REG_CSY  = 3'd3,
        REG_MODE = 3'd4
    } t_reg;

    // one product per operation on the shared multiplier
    typedef enum logic [3:0] {
        OP_UCX,   // u * Cx
        OP_UDX,   // + |u| * Dx, then keep as t
        OP_TSX,   // t * sx, add to total
        OP_VCY,
        OP_VDY,
        OP_TSY,
        OP_DUC,   // du * cx, add to divergence
        OP_DVC,
        OP_DIVQ   // divergence * q0, add to total
    } t_op;

    typedef struct packed {
        logic              load;
        logic              wr;
        logic              rd;
        logic [STEP_W-1:0] step;
        logic              mul;
        logic [1:0]        chunk;
        logic              post;
        t_op               op;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic conservative;
        logic out_full;
    } t_status;

    // neighbour offset of each read step: centre, then x, then y
    function automatic logic signed [2:0] step_off(input logic [STEP_W-1:0] s);
        logic signed [2:0] o;
        case (s)
            4'd1, 4'd7:   o = 3'sd1;
            4'd2, 4'd8:   o = -3'sd1;
            4'd3, 4'd9:   o = 3'sd2;
            4'd4, 4'd10:  o = -3'sd2;
            4'd5, 4'd11:  o = 3'sd3;
            4'd6, 4'd12:  o = -3'sd3;
            default:      o = 3'sd0;
        endcase
        return o;
    endfunction

    // seven-point central part
    function automatic logic signed [7:0] coef_c(input logic signed [2:0] o);
        logic signed [7:0] c;
        case (o)
            3'sd3:   c = 8'sd1;
            3'sd2:   c = -8'sd9;
            3'sd1:   c = 8'sd45;
            -3'sd1:  c = -8'sd45;
            -3'sd2:  c = 8'sd9;
            -3'sd3:  c = -8'sd1;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    // dissipative part, centre handled apart
    function automatic logic signed [7:0] coef_d(input logic signed [2:0] o);
        logic signed [7:0] c;
        case (o)
            3'sd3, -3'sd3: c = -8'sd1;
            3'sd2, -3'sd2: c = 8'sd6;
            3'sd1, -3'sd1: c = -8'sd15;
            default:       c = 8'sd20;
        endcase
        return c;
    endfunction

    // fourth-order central difference
    function automatic logic signed [7:0] coef_e(input logic signed [2:0] o);
        logic signed [7:0] c;
        case (o)
            3'sd2:   c = -8'sd1;
            3'sd1:   c = 8'sd8;
            -3'sd1:  c = -8'sd8;
            -3'sd2:  c = 8'sd1;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

### rtl/uwa_if.sv
// channel interfaces: point items in, rates out, register writes
interface uwa_in_if import uwa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [IDX_W-1:0]         x_index;
    logic [IDX_W-1:0]         y_index;
    logic signed [VAL_W-1:0]  u_value;
    logic signed [VAL_W-1:0]  v_value;
    logic signed [VAL_W-1:0]  q_value;
    modport source (output valid, kind, x_index, y_index, u_value, v_value, q_value,
                    input ready);
    modport sink (input valid, kind, x_index, y_index, u_value, v_value, q_value,
                  output ready);
endinterface

interface uwa_out_if import uwa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  rate_value;
    logic                     saturated;
    modport source (output valid, rate_value, saturated, input ready);
    modport sink (input valid, rate_value, saturated, output ready);
endinterface

interface uwa_cfg_if import uwa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REG_W-1:0]  index;
    logic [VAL_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/uwa_ctrl.sv
// sequencer: item load, grid reads, multiply steps and result hand-off
module uwa_ctrl import uwa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_WRITE, S_READ, S_DRAIN, S_MUL, S_POST, S_RESULT
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_chunk, n_chunk;
    t_op               r_op, n_op;
    logic              last_op;

    assign last_op = (r_op == OP_DIVQ) || (r_op == OP_TSY && !i_status.conservative);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_chunk = r_chunk;
        n_op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                // the item was latched on acceptance; a write finishes now
                if (i_status.kind == KIND_WRITE) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_READ;
                    n_step  = STEP_CENTRE;
                end
            end
            S_READ: begin
                if (r_step == STEP_LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_MUL;
                n_chunk = 2'd0;
                n_op    = OP_UCX;
            end
            S_MUL: begin
                if (r_chunk == CHUNK_LAST) begin
                    n_state = S_POST;
                end else begin
                    n_chunk = r_chunk + 2'd1;
                end
            end
            S_POST: begin
                if (last_op) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_MUL;
                    n_chunk = 2'd0;
                    n_op    = t_op'(r_op + 4'd1);
                end
            end
            S_RESULT: begin
                if (!i_status.out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_chunk <= '0;
            r_op    <= OP_UCX;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_chunk <= n_chunk;
            r_op    <= n_op;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.wr    = (r_state == S_WRITE) && (i_status.kind == KIND_WRITE);
        o_cmd.rd    = (r_state == S_READ);
        o_cmd.step  = r_step;
        o_cmd.mul   = (r_state == S_MUL);
        o_cmd.chunk = r_chunk;
        o_cmd.post  = (r_state == S_POST);
        o_cmd.op    = r_op;
        o_cmd.emit  = (r_state == S_RESULT) && !i_status.out_full;
    end

endmodule

### rtl/uwa_dp.sv
// datapath: grid memories, stencil sums, shared multiplier and saturation
module uwa_dp import uwa_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic                    i_kind,
    input  logic [IDX_W-1:0]        i_x_index,
    input  logic [IDX_W-1:0]        i_y_index,
    input  logic signed [VAL_W-1:0] i_u_value,
    input  logic signed [VAL_W-1:0] i_v_value,
    input  logic signed [VAL_W-1:0] i_q_value,
    input  logic                    i_cfg_valid,
    input  logic [REG_W-1:0]        i_cfg_index,
    input  logic [VAL_W-1:0]        i_cfg_data,
    output logic                    o_cfg_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_rate_value,
    output logic                    o_saturated
);

    function automatic logic [X_W-1:0] fold_x(input logic [IDX_W-1:0] a);
        logic [XF_W-1:0] t;
        t = XF_W'(a);
        for (int i = 0; i < 4; i++) begin
            if (t >= XF_W'(GRID_X)) t = t - XF_W'(GRID_X);
        end
        return t[X_W-1:0];
    endfunction

    function automatic logic [Y_W-1:0] fold_y(input logic [IDX_W-1:0] a);
        logic [YF_W-1:0] t;
        t = YF_W'(a);
        for (int i = 0; i < 4; i++) begin
            if (t >= YF_W'(GRID_Y)) t = t - YF_W'(GRID_Y);
        end
        return t[Y_W-1:0];
    endfunction

    function automatic logic [X_W-1:0] wrap_x(input logic [X_W-1:0] a,
                                              input logic signed [2:0] o);
        logic signed [X_W+1:0] s;
        s = $signed({2'b00, a}) + (X_W+2)'(o);
        if (s < 0) s = s + (X_W+2)'(GRID_X);
        else if (s >= (X_W+2)'(GRID_X)) s = s - (X_W+2)'(GRID_X);
        return s[X_W-1:0];
    endfunction

    function automatic logic [Y_W-1:0] wrap_y(input logic [Y_W-1:0] a,
                                              input logic signed [2:0] o);
        logic signed [Y_W+1:0] s;
        s = $signed({2'b00, a}) + (Y_W+2)'(o);
        if (s < 0) s = s + (Y_W+2)'(GRID_Y);
        else if (s >= (Y_W+2)'(GRID_Y)) s = s - (Y_W+2)'(GRID_Y);
        return s[Y_W-1:0];
    endfunction

    function automatic logic signed [B_W-1:0] mag(input logic signed [VAL_W-1:0] w);
        logic signed [B_W-1:0] t;
        t = B_W'(w);
        return w[VAL_W-1] ? -t : t;
    endfunction

    // configuration
    logic signed [VAL_W-1:0] r_usx, r_usy, r_csx, r_csy;
    logic                    r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usx  <= RST_UPWIND;
            r_usy  <= RST_UPWIND;
            r_csx  <= RST_CENTRAL;
            r_csy  <= RST_CENTRAL;
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_reg'(i_cfg_index))
                REG_USX:  r_usx  <= $signed(i_cfg_data);
                REG_USY:  r_usy  <= $signed(i_cfg_data);
                REG_CSX:  r_csx  <= $signed(i_cfg_data);
                REG_CSY:  r_csy  <= $signed(i_cfg_data);
                REG_MODE: r_mode <= i_cfg_data[0];
                default:  ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // latched item
    logic                    r_kind;
    logic [X_W-1:0]          r_x;
    logic [Y_W-1:0]          r_y;
    logic signed [VAL_W-1:0] r_u, r_v, r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_x    <= fold_x(i_x_index);
            r_y    <= fold_y(i_y_index);
            r_u    <= i_u_value;
            r_v    <= i_v_value;
            r_q    <= i_q_value;
        end
    end

    // grid memories
    logic [VAL_W-1:0]        r_u_mem [0:CELLS-1];
    logic [VAL_W-1:0]        r_v_mem [0:CELLS-1];
    logic [VAL_W-1:0]        r_q_mem [0:CELLS-1];
    logic signed [VAL_W-1:0] r_u_rd, r_v_rd, r_q_rd;
    logic signed [2:0]       rd_off;
    logic [X_W-1:0]          x_nb;
    logic [Y_W-1:0]          y_nb;
    logic [CELL_W-1:0]       q_addr;

    assign rd_off = step_off(i_cmd.step);
    assign x_nb   = wrap_x(r_x, rd_off);
    assign y_nb   = wrap_y(r_y, rd_off);
    assign q_addr = (i_cmd.step > STEP_X_LAST) ? {r_x, y_nb} : {x_nb, r_y};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_u_mem[{r_x, r_y}] <= r_u;
            r_v_mem[{r_x, r_y}] <= r_v;
            r_q_mem[{r_x, r_y}] <= r_q;
        end
        if (i_cmd.rd) begin
            r_u_rd <= $signed(r_u_mem[{x_nb, r_y}]);
            r_v_rd <= $signed(r_v_mem[{r_x, y_nb}]);
            r_q_rd <= $signed(r_q_mem[q_addr]);
        end
    end

    // stencil sums, one read step behind the address
    logic              r_acc_en;
    logic [STEP_W-1:0] r_acc_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.rd;
        end
        r_acc_step <= i_cmd.step;
    end

    logic signed [SUM_W-1:0] r_cx, r_dx, r_cy, r_dy, r_du, r_dv;
    logic signed [VAL_W-1:0] r_q0, r_u0, r_v0;
    logic signed [SUM_W-1:0] q_ext, u_ext, v_ext;
    logic signed [2:0]       acc_off;
    logic signed [7:0]       kc, kd, ke;

    assign q_ext   = SUM_W'(r_q_rd);
    assign u_ext   = SUM_W'(r_u_rd);
    assign v_ext   = SUM_W'(r_v_rd);
    assign acc_off = step_off(r_acc_step);
    assign kc      = coef_c(acc_off);
    assign kd      = coef_d(acc_off);
    assign ke      = coef_e(acc_off);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx <= '0;
            r_dx <= '0;
            r_cy <= '0;
            r_dy <= '0;
            r_du <= '0;
            r_dv <= '0;
        end else if (r_acc_en) begin
            if (r_acc_step == STEP_CENTRE) begin
                r_q0 <= r_q_rd;
                r_u0 <= r_u_rd;
                r_v0 <= r_v_rd;
                r_dx <= r_dx + q_ext * kd;
                r_dy <= r_dy + q_ext * kd;
            end else if (r_acc_step <= STEP_X_LAST) begin
                r_cx <= r_cx + q_ext * kc;
                r_dx <= r_dx + q_ext * kd;
                if (r_acc_step <= STEP_UV_LAST) begin
                    r_du <= r_du + u_ext * ke;
                    r_dv <= r_dv + v_ext * ke;
                end
            end else begin
                r_cy <= r_cy + q_ext * kc;
                r_dy <= r_dy + q_ext * kd;
            end
        end
    end

    // shared multiplier: 17 x 33 bits per cycle over four chunks of a
    logic signed [A_W-1:0]   a_op;
    logic signed [B_W-1:0]   b_op;
    logic                    keep;
    logic [CHUNK_W-1:0]      a_bits;
    logic signed [CHUNK_W:0] a_chunk;
    logic signed [PP_W-1:0]  pp;
    logic signed [ACC_W-1:0] pp_ext, pp_sh;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [A_W-1:0]   r_t, r_div;
    logic signed [TOT_W-1:0] r_tot, acc_sh;

    always_comb begin
        case (i_cmd.op)
            OP_UCX:  begin a_op = A_W'(r_cx); b_op = B_W'(r_u0);  end
            OP_UDX:  begin a_op = A_W'(r_dx); b_op = mag(r_u0);   end
            OP_TSX:  begin a_op = r_t;        b_op = B_W'(r_usx); end
            OP_VCY:  begin a_op = A_W'(r_cy); b_op = B_W'(r_v0);  end
            OP_VDY:  begin a_op = A_W'(r_dy); b_op = mag(r_v0);   end
            OP_TSY:  begin a_op = r_t;        b_op = B_W'(r_usy); end
            OP_DUC:  begin a_op = A_W'(r_du); b_op = B_W'(r_csx); end
            OP_DVC:  begin a_op = A_W'(r_dv); b_op = B_W'(r_csy); end
            OP_DIVQ: begin a_op = r_div;      b_op = B_W'(r_q0);  end
            default: begin a_op = '0;         b_op = '0;          end
        endcase
    end

    assign keep    = (i_cmd.op == OP_UDX) || (i_cmd.op == OP_VDY);
    assign a_bits  = a_op[i_cmd.chunk * CHUNK_W +: CHUNK_W];
    // top chunk carries the sign, the others are plain magnitude bits
    assign a_chunk = (i_cmd.chunk == CHUNK_LAST) ? $signed({a_bits[CHUNK_W-1], a_bits})
                                                 : $signed({1'b0, a_bits});
    assign pp      = a_chunk * b_op;
    assign pp_ext  = ACC_W'(pp);

    always_comb begin
        case (i_cmd.chunk)
            2'd0:    pp_sh = pp_ext;
            2'd1:    pp_sh = pp_ext <<< CHUNK_W;
            2'd2:    pp_sh = pp_ext <<< (2 * CHUNK_W);
            default: pp_sh = pp_ext <<< (3 * CHUNK_W);
        endcase
    end

    assign acc_sh = r_acc[ACC_W-1:16];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            if (i_cmd.chunk == 2'd0 && !keep) r_acc <= pp_sh;
            else r_acc <= r_acc + pp_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tot <= '0;
            r_div <= '0;
        end else if (i_cmd.post) begin
            case (i_cmd.op)
                OP_UDX, OP_VDY:          r_t   <= acc_sh[A_W-1:0];
                OP_TSX, OP_TSY, OP_DIVQ: r_tot <= r_tot + acc_sh;
                OP_DUC, OP_DVC:          r_div <= r_div + acc_sh[A_W-1:0];
                default:                 ;
            endcase
        end
    end

    // negate and clip to 32 bits
    logic signed [TOT_W-1:0] neg;
    logic                    fits;

    assign neg  = -r_tot;
    assign fits = (~|neg[TOT_W-1:VAL_W-1]) || (&neg[TOT_W-1:VAL_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_saturated <= !fits;
            if (fits) o_rate_value <= neg[VAL_W-1:0];
            else if (neg[TOT_W-1]) o_rate_value <= {1'b1, {(VAL_W-1){1'b0}}};
            else o_rate_value <= {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    assign o_status.kind         = r_kind;
    assign o_status.conservative = r_mode;
    assign o_status.out_full     = o_out_valid && !i_out_ready;

endmodule

### rtl/upwind_fifth_order_advection.sv
// top level of the fifth-order upwind advection rate block
// Holds a periodic 32 x 32 grid of velocities u, v and field q in three single-port
// memories and answers rate requests with the fifth-order upwind stencil, Q16.16,
// saturated to 32 bits. A write transaction stores one point and gives no result;
// the next item is taken once the block is back in idle. A rate transaction latches
// the item, reads the centre and its x and y neighbours (the q memory gives one
// neighbour per read, u and v read alongside), finishes the sums, then forms 6
// products in plain mode or 9 in conservative mode on one shared 17 x 33 bit
// multiplier, each as four partial products and a fold of the sum, loads the
// output register and goes back to idle, where it takes the next item; a result
// held by the receiver stalls it.
// Indices wrap modulo the grid size; reading a point never written gives no defined
// answer. Register writes are always accepted and belong while the block is idle.
module upwind_fifth_order_advection import uwa_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    uwa_in_if.sink   i_in,
    uwa_out_if.source o_out,
    uwa_cfg_if.sink  i_cfg
);

    t_cmd    cmd;
    t_status status;

    // sequencer: owns input handshake and the step order
    uwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: memories, sums, multiplier, output register
    uwa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_kind       (i_in.kind),
        .i_x_index    (i_in.x_index),
        .i_y_index    (i_in.y_index),
        .i_u_value    (i_in.u_value),
        .i_v_value    (i_in.v_value),
        .i_q_value    (i_in.q_value),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_cfg_ready  (i_cfg.ready),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_rate_value (o_out.rate_value),
        .o_saturated  (o_out.saturated)
    );

endmodule

### rtl/uwa_checker.sv
// port-level checks on the advection block, bound to the top level
module uwa_checker import uwa_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [VAL_W-1:0]  i_out_rate,
    input logic              i_out_sat
);

    // an accepted item always occupies the block for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transaction");

    // a result never appears in the cycle after an item was taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready))
        else $error("result too soon after input transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_rate) && $stable(i_out_sat))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind upwind_fifth_order_advection uwa_checker u_uwa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_rate  (o_out.rate_value),
    .i_out_sat   (o_out.saturated)
);

### dv/uwa_tb_if.sv
`timescale 1ns / 1ps
// note: the channel interfaces live in rtl/uwa_if.sv; this file holds the testbench's shared types
package uwa_tb_pkg;
    import uwa_pkg::*;

    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        x_index;
        logic [IDX_W-1:0]        y_index;
        logic signed [VAL_W-1:0] u_value;
        logic signed [VAL_W-1:0] v_value;
        logic signed [VAL_W-1:0] q_value;
    } t_point_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] rate_value;
        logic                    saturated;
    } t_rate_item;
endpackage

### dv/upwind_fifth_order_advection_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the fifth-order upwind advection rate block
module upwind_fifth_order_advection_tb;
    import uwa_pkg::*;
    import uwa_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    uwa_in_if  in_ch ();
    uwa_out_if out_ch ();
    uwa_cfg_if cfg_ch ();

    upwind_fifth_order_advection dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the grid and registers
    logic signed [31:0] u_grid [CELLS];
    logic signed [31:0] v_grid [CELLS];
    logic signed [31:0] q_grid [CELLS];
    bit                 written [CELLS];
    logic signed [31:0] scale_ux, scale_uy, scale_cx, scale_cy;
    logic               cons_mode;

    t_rate_item rates_due [$];
    int         fail_count = 0;

    function automatic int cell_of(int x, int y);
        return (((x % GRID_X) + GRID_X) % GRID_X) * GRID_Y + (((y % GRID_Y) + GRID_Y) % GRID_Y);
    endfunction

    // upwind product along one axis, scaled, Q16.16 with 64-bit range kept
    function automatic logic signed [127:0] upwind_term(int x, int y, int ox, int oy,
                                                        logic signed [31:0] w,
                                                        logic signed [31:0] sc);
        logic signed [127:0] p3, p2, p1, p0, m1, m2, m3, c, d, aw, acc, t;
        logic signed [63:0] t64;
        p3 = q_grid[cell_of(x + 3*ox, y + 3*oy)];
        p2 = q_grid[cell_of(x + 2*ox, y + 2*oy)];
        p1 = q_grid[cell_of(x + ox, y + oy)];
        p0 = q_grid[cell_of(x, y)];
        m1 = q_grid[cell_of(x - ox, y - oy)];
        m2 = q_grid[cell_of(x - 2*ox, y - 2*oy)];
        m3 = q_grid[cell_of(x - 3*ox, y - 3*oy)];
        c = p3 - 9*p2 + 45*(p1 - m1) + 9*m2 - m3;
        d = -p3 + 6*p2 - 15*p1 + 20*p0 - 15*m1 + 6*m2 - m3;
        aw = (w < 0) ? -$signed(128'(w)) : 128'(w);
        acc = 128'(w) * c + aw * d;
        t64 = 64'(acc >>> 16);   // keep low 64 bits, as a signed value
        t = t64;
        return (t * 128'(sc)) >>> 16;
    endfunction

    function automatic logic signed [127:0] central_term(bit use_u, int x, int y, int ox, int oy,
                                                         logic signed [31:0] sc);
        logic signed [127:0] d, r;
        logic signed [63:0] r64;
        if (use_u)
            d = -128'(u_grid[cell_of(x+2*ox, y+2*oy)]) + 8*128'(u_grid[cell_of(x+ox, y+oy)])
                - 8*128'(u_grid[cell_of(x-ox, y-oy)]) + 128'(u_grid[cell_of(x-2*ox, y-2*oy)]);
        else
            d = -128'(v_grid[cell_of(x+2*ox, y+2*oy)]) + 8*128'(v_grid[cell_of(x+ox, y+oy)])
                - 8*128'(v_grid[cell_of(x-ox, y-oy)]) + 128'(v_grid[cell_of(x-2*ox, y-2*oy)]);
        r = (d * 128'(sc)) >>> 16;
        r64 = 64'(r);
        return r64;
    endfunction

    function automatic t_rate_item advection_rate(int x, int y);
        logic signed [127:0] total, dv;
        t_rate_item r;
        int cl;
        cl = cell_of(x, y);
        total = upwind_term(x, y, 1, 0, u_grid[cl], scale_ux)
              + upwind_term(x, y, 0, 1, v_grid[cl], scale_uy);
        if (cons_mode) begin
            dv = central_term(1, x, y, 1, 0, scale_cx) + central_term(0, x, y, 0, 1, scale_cy);
            dv = 64'(dv);
            total = total + ((dv * 128'(q_grid[cl])) >>> 16);
        end
        total = -total;
        if (total > 128'sd2147483647) begin
            r.rate_value = 32'sh7fffffff; r.saturated = 1'b1;
        end else if (total < -128'sd2147483648) begin
            r.rate_value = 32'sh80000000; r.saturated = 1'b1;
        end else begin
            r.rate_value = 32'(total); r.saturated = 1'b0;
        end
        return r;
    endfunction

    // a rate is only requested where the whole stencil has been written
    function automatic bit stencil_ready(int x, int y);
        for (int k = -3; k <= 3; k++)
            if (!written[cell_of(x + k, y)] || !written[cell_of(x, y + k)]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void model_apply(t_point_item it);
        int cl;
        cl = cell_of(it.x_index, it.y_index);
        if (it.kind == KIND_WRITE) begin
            u_grid[cl] = it.u_value; v_grid[cl] = it.v_value; q_grid[cl] = it.q_value;
            written[cl] = 1'b1;
        end else begin
            rates_due.push_back(advection_rate(it.x_index, it.y_index));
        end
    endfunction

    task automatic send_item(t_point_item it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        repeat (gap) @(negedge i_clk);
        in_ch.valid   = 1'b1;
        in_ch.kind    = it.kind;
        in_ch.x_index = it.x_index;
        in_ch.y_index = it.y_index;
        in_ch.u_value = it.u_value;
        in_ch.v_value = it.v_value;
        in_ch.q_value = it.q_value;
        do @(posedge i_clk); while (!in_ch.ready);
        model_apply(it);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (rates_due.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [31:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_USX:  scale_ux = val;
            REG_USY:  scale_uy = val;
            REG_CSX:  scale_cx = val;
            REG_CSY:  scale_cy = val;
            REG_MODE: cons_mode = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic t_point_item make_write(int x, int y, logic [31:0] u, logic [31:0] v,
                                               logic [31:0] q);
        t_point_item it;
        it.kind = KIND_WRITE; it.x_index = IDX_W'(x); it.y_index = IDX_W'(y);
        it.u_value = u; it.v_value = v; it.q_value = q;
        return it;
    endfunction

    function automatic t_point_item make_rate(int x, int y);
        t_point_item it;
        it = make_write(x, y, $urandom, $urandom, $urandom);
        it.kind = KIND_RATE;
        return it;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 131072)) - 65536);
            default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    // receiver: random stall, compare against the oldest expected rate
    initial begin
        t_rate_item want;
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            out_ch.ready = 1'b0;
            repeat (stall) @(negedge i_clk);
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if (rates_due.size() == 0) begin
                $error("unexpected rate transaction: rate_value %0d", out_ch.rate_value);
                fail_count++;
            end else begin
                want = rates_due.pop_front();
                if (out_ch.rate_value !== want.rate_value) begin
                    $error("rate_value: expected %0d, actual %0d",
                           want.rate_value, out_ch.rate_value);
                    fail_count++;
                end
                if (out_ch.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, actual %0b",
                           want.saturated, out_ch.saturated);
                    fail_count++;
                end
            end
        end
    end

    // directed table: rows that fill a region and probe extremes
    typedef struct {
        bit          is_rate;
        int          x, y;
        logic [31:0] u, v, q;
        bit          typed;
        t_rate_item  typed_rate;
    } t_row;

    t_row rows [$];

    initial begin
        t_point_item it;
        t_rate_item  want;
        int x, y;

        in_ch.valid = 1'b0; in_ch.kind = KIND_WRITE; in_ch.x_index = '0; in_ch.y_index = '0;
        in_ch.u_value = '0; in_ch.v_value = '0; in_ch.q_value = '0;
        cfg_ch.valid = 1'b0; cfg_ch.index = REG_USX; cfg_ch.data = '0;
        scale_ux = RST_UPWIND; scale_uy = RST_UPWIND;
        scale_cx = RST_CENTRAL; scale_cy = RST_CENTRAL; cons_mode = 1'b0;
        foreach (written[i]) begin
            written[i] = 1'b0; u_grid[i] = '0; v_grid[i] = '0; q_grid[i] = '0;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // flat field along both axes through the origin: the stencil gives zero at reset scales
        for (int k = -3; k <= 3; k++) begin
            rows.push_back('{0, k & 31, 0, 32'h7fffffff, 32'h80000000, 32'h00010000, 0, '{0, 0}});
            if (k != 0)
                rows.push_back('{0, 0, k & 31, 32'h80000000, 32'h7fffffff, 32'h00010000,
                                 0, '{0, 0}});
        end
        rows.push_back('{1, 0, 0, 0, 0, 0, 1, '{32'sd0, 1'b0}});
        // one spike at the origin, extreme velocities: rate checked by the predictor
        rows.push_back('{0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, '{0, 0}});
        rows.push_back('{1, 0, 0, 0, 0, 0, 0, '{0, 0}});
        rows.push_back('{0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, '{0, 0}});
        rows.push_back('{1, 0, 0, 0, 0, 0, 0, '{0, 0}});
        // neighbour across the x wrap changed, origin asked again
        rows.push_back('{0, 31, 0, 32'hffffffff, 32'h0, 32'hffffffff, 0, '{0, 0}});
        rows.push_back('{1, 0, 0, 0, 0, 0, 0, '{0, 0}});

        foreach (rows[r]) begin
            if (rows[r].is_rate) it = make_rate(rows[r].x, rows[r].y);
            else it = make_write(rows[r].x, rows[r].y, rows[r].u, rows[r].v, rows[r].q);
            send_item(it);
            if (rows[r].typed) begin
                want = rates_due[$];
                if (want !== rows[r].typed_rate) begin
                    $error("rate_value: expected %0d, actual %0d",
                           rows[r].typed_rate.rate_value, want.rate_value);
                    fail_count++;
                end
            end
        end
        wait_idle();

        // fill a band of sixteen columns across the x wrap, every row
        for (int c = 0; c < CELLS / 2; c++) begin
            x = (c / GRID_Y + 26) % GRID_X; y = c % GRID_Y;
            if (!written[cell_of(x, y)])
                send_item(make_write(x, y, rand_value(), rand_value(), rand_value()));
        end

        // random phases, each with its own register setting
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_reg(REG_MODE, 32'd1);
                end
                1: begin
                    write_reg(REG_USX, 32'h7fffffff); write_reg(REG_USY, 32'h80000000);
                    write_reg(REG_CSX, 32'h80000000); write_reg(REG_CSY, 32'h7fffffff);
                end
                2: begin
                    write_reg(REG_USX, 32'h0); write_reg(REG_USY, 32'h0);
                    write_reg(REG_CSX, 32'hffffffff); write_reg(REG_CSY, 32'h1);
                    write_reg(REG_MODE, 32'd0);
                end
                default: begin
                    write_reg(REG_USX, $urandom); write_reg(REG_USY, $urandom);
                    write_reg(REG_CSX, $urandom); write_reg(REG_CSY, $urandom);
                    write_reg(REG_MODE, $urandom);
                end
            endcase
            for (int n = 0; n < 100; n++) begin
                x = (26 + $urandom_range(0, 15)) % GRID_X; y = $urandom_range(0, 31);
                if ($urandom_range(0, 2) == 0)
                    send_item(make_write(x, y, rand_value(), rand_value(), rand_value()));
                else if (stencil_ready(x, y))
                    send_item(make_rate(x, y));
                // midway through phase 1, hold the sender until every outstanding rate has come back
                if (n == 50 && phase == 1)
                    while (rates_due.size() != 0) @(negedge i_clk);
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("[upwind_fifth_order_advection] OK");
        else
            $display("[upwind_fifth_order_advection] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("[upwind_fifth_order_advection] ERROR");
        $finish;
    end
endmodule
